@@ hdl/register_machine_execute_unit_top_macros.svh @@
// Assertion macros for the execute unit checker.
`ifndef REGISTER_MACHINE_EXECUTE_UNIT_TOP_MACROS_SVH
`define REGISTER_MACHINE_EXECUTE_UNIT_TOP_MACROS_SVH
// implication checked every clock, off in reset
`define RMEU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define RMEU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ hdl/rmeu_pkg.sv @@
package rmeu_pkg;
  localparam int NumRegs = 32;
  localparam int NumArrays = 8;
  localparam int ArrayDepth = 64;
  localparam int ProgDepth = 1024;
  localparam int DataWidth = 32;
  localparam int RegW = $clog2(NumRegs);
  localparam int ArrW = $clog2(NumArrays);
  localparam int IdxW = $clog2(ArrayDepth);
  localparam int LenW = IdxW + 1;
  localparam int PcW = $clog2(ProgDepth);
  localparam int MemDepth = NumArrays * ArrayDepth;
  localparam int MemAw = $clog2(MemDepth);
  localparam int CntW = $clog2(DataWidth + 1);

  typedef enum logic [4:0] {
    ACT_ASSIGN = 5'd0, ACT_CLEAR = 5'd1, ACT_APPEND = 5'd2, ACT_ACCESS = 5'd3,
    ACT_ADD = 5'd4, ACT_SUB = 5'd5, ACT_MUL = 5'd6, ACT_DIV = 5'd7,
    ACT_MOD = 5'd8, ACT_INC = 5'd9, ACT_DEC = 5'd10, ACT_JEQ = 5'd11,
    ACT_JNE = 5'd12, ACT_JGT = 5'd13, ACT_JLT = 5'd14, ACT_JLE = 5'd15,
    ACT_JGE = 5'd16, ACT_NOP = 5'd17
  } action_t;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_DIV0 = 2'd1, ERR_RANGE = 2'd2, ERR_FULL = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_OPER, ST_EXEC, ST_DIV, ST_MEMRD, ST_DONE
  } state_t;

  typedef struct packed {
    logic [4:0]  action;
    logic [4:0]  dest_reg;
    logic        a_is_reg;
    logic [4:0]  a_reg;
    logic signed [31:0] a_imm;
    logic        b_is_reg;
    logic [4:0]  b_reg;
    logic signed [31:0] b_imm;
    logic [9:0]  jump_target;
    logic [2:0]  array_id;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  next_pc;
    logic        branch_taken;
    logic        reg_written;
    logic signed [31:0] written_value;
    logic [1:0]  error_code;
  } out_word_t;

  typedef struct packed {
    logic latch_in;
    logic read_ops;
    logic exec;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic mem_read;
    logic div_last;
  } status_t;
endpackage

@@ hdl/rmeu_ram.sv @@
module rmeu_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/rmeu_ctrl.sv @@
module rmeu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rmeu_pkg::status_t status,
  output rmeu_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  rmeu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmeu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rmeu_pkg::ST_IDLE: if (start) state_next = rmeu_pkg::ST_OPER;
      rmeu_pkg::ST_OPER: begin
        if (status.is_div) state_next = rmeu_pkg::ST_DIV;
        else if (status.mem_read) state_next = rmeu_pkg::ST_MEMRD;
        else state_next = rmeu_pkg::ST_EXEC;
      end
      rmeu_pkg::ST_MEMRD: state_next = rmeu_pkg::ST_EXEC;
      rmeu_pkg::ST_DIV: if (status.div_last) state_next = rmeu_pkg::ST_EXEC;
      rmeu_pkg::ST_EXEC: state_next = rmeu_pkg::ST_DONE;
      rmeu_pkg::ST_DONE: state_next = rmeu_pkg::ST_IDLE;
      default: state_next = rmeu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      rmeu_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.latch_in = start;
      end
      rmeu_pkg::ST_OPER: cmd.read_ops = 1'b1;
      rmeu_pkg::ST_DIV: cmd.div_step = 1'b1;
      rmeu_pkg::ST_EXEC: cmd.exec = 1'b1;
      rmeu_pkg::ST_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end
endmodule

@@ hdl/rmeu_datapath.sv @@
module rmeu_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rmeu_pkg::cmd_t      cmd,
  input  rmeu_pkg::in_word_t  in_word,
  output rmeu_pkg::status_t   status,
  output rmeu_pkg::out_word_t out_word
);
  localparam int W = rmeu_pkg::DataWidth;

  rmeu_pkg::in_word_t ins;
  logic [W-1:0] regs [rmeu_pkg::NumRegs];
  logic [rmeu_pkg::LenW-1:0] alen [rmeu_pkg::NumArrays];
  logic [rmeu_pkg::PcW-1:0] pc;
  logic [W-1:0] a, b, d;
  logic [W-1:0] prod;
  logic [W-1:0] rem, quo, divisor;
  logic [rmeu_pkg::CntW-1:0] cnt;
  logic [W-1:0] mem_rdata;
  logic mem_we;
  logic [rmeu_pkg::MemAw-1:0] mem_waddr, mem_raddr;
  logic [rmeu_pkg::RegW-1:0] dest;
  logic [rmeu_pkg::ArrW-1:0] arr;
  logic [rmeu_pkg::LenW-1:0] len_cur;
  logic [4:0] act;
  logic na, nb;
  logic [W:0] trial;
  logic [W-1:0] op_a, op_b;

  assign act = ins.action;
  assign dest = ins.dest_reg[rmeu_pkg::RegW-1:0];
  assign arr = ins.array_id[rmeu_pkg::ArrW-1:0];
  assign len_cur = alen[arr];
  assign na = a[W-1];
  assign nb = b[W-1];

  assign op_a = ins.a_is_reg ? regs[ins.a_reg[rmeu_pkg::RegW-1:0]] : W'(ins.a_imm);
  assign op_b = ins.b_is_reg ? regs[ins.b_reg[rmeu_pkg::RegW-1:0]] : W'(ins.b_imm);

  assign status.is_div = (act == rmeu_pkg::ACT_DIV || act == rmeu_pkg::ACT_MOD)
                         && (op_b != '0);
  assign status.mem_read = (act == rmeu_pkg::ACT_ACCESS);
  assign status.div_last = (cnt == rmeu_pkg::CntW'(1));

  assign mem_we = cmd.exec && act == rmeu_pkg::ACT_APPEND
                  && len_cur < rmeu_pkg::LenW'(rmeu_pkg::ArrayDepth);
  assign mem_waddr = {arr, len_cur[rmeu_pkg::IdxW-1:0]};
  assign mem_raddr = {arr, a[rmeu_pkg::IdxW-1:0]};

  rmeu_ram #(.Width(W), .Depth(rmeu_pkg::MemDepth)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(a),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign trial = {rem[W-2:0], quo[W-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.latch_in) ins <= in_word;
    if (cmd.read_ops) begin
      a <= op_a;
      b <= op_b;
      d <= regs[dest];
      prod <= op_a * op_b;
      rem <= '0;
      quo <= op_a[W-1] ? W'(-op_a) : op_a;
      divisor <= op_b[W-1] ? W'(-op_b) : op_b;
      cnt <= rmeu_pkg::CntW'(W);
    end
    if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  logic wr, tk, cond;
  logic [W-1:0] val;
  logic [1:0] err;
  logic lt_ab, lt_ba;
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);

  always_comb begin
    wr = 1'b0;
    tk = 1'b0;
    cond = 1'b0;
    val = '0;
    err = rmeu_pkg::ERR_OK;
    case (act)
      rmeu_pkg::ACT_ASSIGN: begin val = a; wr = 1'b1; end
      rmeu_pkg::ACT_APPEND:
        if (len_cur >= rmeu_pkg::LenW'(rmeu_pkg::ArrayDepth)) err = rmeu_pkg::ERR_FULL;
      rmeu_pkg::ACT_ACCESS:
        if (na || a >= W'(len_cur)) err = rmeu_pkg::ERR_RANGE;
        else begin val = mem_rdata; wr = 1'b1; end
      rmeu_pkg::ACT_ADD: begin val = a + b; wr = 1'b1; end
      rmeu_pkg::ACT_SUB: begin val = a - b; wr = 1'b1; end
      rmeu_pkg::ACT_MUL: begin val = prod; wr = 1'b1; end
      rmeu_pkg::ACT_DIV:
        if (b == '0) err = rmeu_pkg::ERR_DIV0;
        else begin val = (na != nb) ? W'(-quo) : quo; wr = 1'b1; end
      rmeu_pkg::ACT_MOD:
        if (b == '0) err = rmeu_pkg::ERR_DIV0;
        else begin val = na ? W'(-rem) : rem; wr = 1'b1; end
      rmeu_pkg::ACT_INC: begin val = d + 1'b1; wr = 1'b1; end
      rmeu_pkg::ACT_DEC: begin val = d - 1'b1; wr = 1'b1; end
      rmeu_pkg::ACT_JEQ: begin cond = (a == b); tk = 1'b1; end
      rmeu_pkg::ACT_JNE: begin cond = (a != b); tk = 1'b1; end
      rmeu_pkg::ACT_JGT: begin cond = lt_ba; tk = 1'b1; end
      rmeu_pkg::ACT_JLT: begin cond = lt_ab; tk = 1'b1; end
      rmeu_pkg::ACT_JLE: begin cond = !lt_ba; tk = 1'b1; end
      rmeu_pkg::ACT_JGE: begin cond = !lt_ab; tk = 1'b1; end
      default: ;
    endcase
    tk = tk && cond;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      for (int i = 0; i < rmeu_pkg::NumRegs; i++) regs[i] <= '0;
      for (int i = 0; i < rmeu_pkg::NumArrays; i++) alen[i] <= '0;
    end else if (cmd.exec) begin
      if (wr) regs[dest] <= val;
      if (act == rmeu_pkg::ACT_CLEAR) alen[arr] <= '0;
      if (mem_we) alen[arr] <= len_cur + 1'b1;
      pc <= tk ? rmeu_pkg::PcW'(ins.jump_target[rmeu_pkg::PcW-1:0] + 1'b1)
               : rmeu_pkg::PcW'(pc + 1'b1);
      out_word.next_pc <= 10'(tk ? rmeu_pkg::PcW'(ins.jump_target[rmeu_pkg::PcW-1:0] + 1'b1)
                                 : rmeu_pkg::PcW'(pc + 1'b1));
      out_word.branch_taken <= tk;
      out_word.reg_written <= wr;
      out_word.written_value <= wr ? val : '0;
      out_word.error_code <= err;
    end
  end
endmodule

@@ hdl/register_machine_execute_unit_top.sv @@
// Register machine execute unit.
// Input channel: drive the decoded instruction on in_word and raise start;
// it is taken at a clock edge where start is high and busy is low.
// Result channel: out_word is valid for one cycle while done is high; the
// receiver cannot stall, so every result must be taken in that cycle.
// Sequence: from the accepting edge the controller steps through OPER, EXEC
// and DONE for most instructions; an array access adds MEMRD (one registered
// memory read), and div or mod with a nonzero divisor adds DIV (32 restoring
// steps, one quotient bit per cycle) before EXEC.
// busy is low again the cycle after done, so a new instruction is taken only
// once the last one is through; divide keeps busy high longest.
// Reset (synchronous, rst high) clears the program counter, all registers
// and all array lengths; array contents are undefined until appended.
module register_machine_execute_unit_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rmeu_pkg::in_word_t  in_word,
  output logic                busy,
  output logic                done,
  output rmeu_pkg::out_word_t out_word
);
  rmeu_pkg::cmd_t    cmd;
  rmeu_pkg::status_t status;

  rmeu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status),
    .cmd(cmd), .busy(busy), .done(done)
  );

  rmeu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_word),
    .status(status), .out_word(out_word)
  );
endmodule

@@ hdl/rmeu_checker.sv @@
`include "register_machine_execute_unit_top_macros.svh"
module rmeu_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input rmeu_pkg::out_word_t out_word
);
  `RMEU_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `RMEU_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy)
  `RMEU_ASSERT_IMPL(a_done_busy, clk, rst, done, busy)
  `RMEU_ASSERT_IMPL(a_wr_value, clk, rst, done && !out_word.reg_written, out_word.written_value == '0)
endmodule

bind register_machine_execute_unit_top rmeu_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .out_word(out_word)
);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  rmeu_pkg::in_word_t in_word = '0;
  logic busy, done;
  rmeu_pkg::out_word_t out_word;

  register_machine_execute_unit_top dut (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word),
    .busy(busy), .done(done), .out_word(out_word)
  );

  always #5 clk = ~clk;

  // shadow machine state
  logic [9:0]  shadow_pc;
  logic [31:0] shadow_regs [rmeu_pkg::NumRegs];
  logic [31:0] shadow_arrays [rmeu_pkg::NumArrays][rmeu_pkg::ArrayDepth];
  int          shadow_len [rmeu_pkg::NumArrays];
  rmeu_pkg::out_word_t pending_words [$];
  int          fail_count = 0;
  int          cycle_count = 0;

  typedef struct {
    rmeu_pkg::in_word_t  word;
    bit                  typed;
    rmeu_pkg::out_word_t result;
  } row_t;
  row_t rows [$];

  function automatic logic [31:0] pick(logic is_reg, logic [4:0] r, logic [31:0] imm);
    return is_reg ? shadow_regs[r] : imm;
  endfunction

  function automatic rmeu_pkg::out_word_t execute_word(rmeu_pkg::in_word_t w);
    logic [31:0] a, b, val, ma, mb;
    logic signed [31:0] sa, sb;
    bit wr, cond;
    rmeu_pkg::err_t err;
    rmeu_pkg::out_word_t o;
    a = pick(w.a_is_reg, w.a_reg, w.a_imm);
    b = pick(w.b_is_reg, w.b_reg, w.b_imm);
    sa = a;
    sb = b;
    wr = 0; cond = 0; val = '0; err = rmeu_pkg::ERR_OK;
    case (w.action)
      rmeu_pkg::ACT_ASSIGN: begin val = a; wr = 1; end
      rmeu_pkg::ACT_CLEAR: shadow_len[w.array_id] = 0;
      rmeu_pkg::ACT_APPEND: begin
        if (shadow_len[w.array_id] >= rmeu_pkg::ArrayDepth) err = rmeu_pkg::ERR_FULL;
        else begin
          shadow_arrays[w.array_id][shadow_len[w.array_id]] = a;
          shadow_len[w.array_id]++;
        end
      end
      rmeu_pkg::ACT_ACCESS: begin
        if (a[31] || a >= shadow_len[w.array_id]) err = rmeu_pkg::ERR_RANGE;
        else begin val = shadow_arrays[w.array_id][a]; wr = 1; end
      end
      rmeu_pkg::ACT_ADD: begin val = a + b; wr = 1; end
      rmeu_pkg::ACT_SUB: begin val = a - b; wr = 1; end
      rmeu_pkg::ACT_MUL: begin val = a * b; wr = 1; end
      rmeu_pkg::ACT_DIV, rmeu_pkg::ACT_MOD: begin
        if (b == 0) err = rmeu_pkg::ERR_DIV0;
        else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          if (w.action == rmeu_pkg::ACT_DIV) begin
            val = ma / mb;
            if (a[31] != b[31]) val = -val;
          end else begin
            val = ma % mb;
            if (a[31]) val = -val;
          end
          wr = 1;
        end
      end
      rmeu_pkg::ACT_INC: begin val = shadow_regs[w.dest_reg] + 1; wr = 1; end
      rmeu_pkg::ACT_DEC: begin val = shadow_regs[w.dest_reg] - 1; wr = 1; end
      rmeu_pkg::ACT_JEQ: cond = (a == b);
      rmeu_pkg::ACT_JNE: cond = (a != b);
      rmeu_pkg::ACT_JGT: cond = (sa > sb);
      rmeu_pkg::ACT_JLT: cond = (sa < sb);
      rmeu_pkg::ACT_JLE: cond = (sa <= sb);
      rmeu_pkg::ACT_JGE: cond = (sa >= sb);
      default: ;
    endcase
    if (wr) shadow_regs[w.dest_reg] = val;
    shadow_pc = cond ? w.jump_target + 10'd1 : shadow_pc + 10'd1;
    o.next_pc = shadow_pc;
    o.branch_taken = cond;
    o.reg_written = wr;
    o.written_value = wr ? val : '0;
    o.error_code = err;
    return o;
  endfunction

  function automatic rmeu_pkg::in_word_t random_word();
    rmeu_pkg::in_word_t w;
    logic [127:0] raw;
    int r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(rmeu_pkg::in_word_t)-1:0];
    r = $urandom_range(0, 99);
    w.action = (r < 3) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
    if (w.action inside {rmeu_pkg::ACT_ACCESS, rmeu_pkg::ACT_APPEND})
      w.array_id = 3'($urandom_range(0, 1));
    if (w.action == rmeu_pkg::ACT_ACCESS && $urandom_range(0, 3) != 0) begin
      w.a_is_reg = 1'b0;
      w.a_imm = $urandom_range(0, 66);
    end
    if ($urandom_range(0, 3) == 0) w.a_imm = $urandom_range(0, 20) - 10;
    if ($urandom_range(0, 3) == 0) w.b_imm = $urandom_range(0, 20) - 10;
    if ($urandom_range(0, 9) == 0) w.b_imm = '0;
    if (w.action == rmeu_pkg::ACT_CLEAR && $urandom_range(0, 3) != 0)
      w.action = rmeu_pkg::ACT_APPEND;
    return w;
  endfunction

  function automatic rmeu_pkg::in_word_t mk(rmeu_pkg::action_t act, logic [4:0] dst,
                                            logic ar, logic [4:0] ra, logic [31:0] ia,
                                            logic br, logic [4:0] rb, logic [31:0] ib,
                                            logic [9:0] tgt, logic [2:0] arr);
    rmeu_pkg::in_word_t w;
    w.action = act; w.dest_reg = dst; w.a_is_reg = ar; w.a_reg = ra; w.a_imm = ia;
    w.b_is_reg = br; w.b_reg = rb; w.b_imm = ib; w.jump_target = tgt; w.array_id = arr;
    return w;
  endfunction

  task automatic add_row(rmeu_pkg::in_word_t w, bit typed = 0,
                         rmeu_pkg::out_word_t res = '0);
    row_t r;
    r.word = w; r.typed = typed; r.result = res;
    rows.insert(rows.size(), r);
  endtask

  task automatic send_word(rmeu_pkg::in_word_t w, bit typed, rmeu_pkg::out_word_t res);
    rmeu_pkg::out_word_t exp_word;
    in_word <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_word = execute_word(w);
    if (typed && exp_word != res) begin
      $error("typed row disagrees with predictor: %h vs %h", res, exp_word);
      fail_count++;
    end
    pending_words.insert(pending_words.size(), typed ? res : exp_word);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result %h", out_word);
        fail_count++;
      end else begin
        rmeu_pkg::out_word_t e;
        e = pending_words.pop_front();
        if (out_word.next_pc !== e.next_pc) begin
          $error("next_pc exp %0d got %0d", e.next_pc, out_word.next_pc); fail_count++;
        end
        if (out_word.branch_taken !== e.branch_taken) begin
          $error("branch_taken exp %0d got %0d", e.branch_taken, out_word.branch_taken);
          fail_count++;
        end
        if (out_word.reg_written !== e.reg_written) begin
          $error("reg_written exp %0d got %0d", e.reg_written, out_word.reg_written);
          fail_count++;
        end
        if (out_word.written_value !== e.written_value) begin
          $error("written_value exp %0d got %0d", e.written_value, out_word.written_value);
          fail_count++;
        end
        if (out_word.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, out_word.error_code);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("register_machine_execute_unit_top test failed");
      $finish;
    end
  end

  initial begin
    shadow_pc = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_len[i]) shadow_len[i] = 0;
    // directed rows; typed results where obvious
    add_row(mk(rmeu_pkg::ACT_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            '{10'd1, 1'b0, 1'b0, 32'd0, rmeu_pkg::ERR_OK});
    add_row(mk(rmeu_pkg::ACT_ASSIGN, 1, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0), 1,
            '{10'd2, 1'b0, 1'b1, 32'h7fffffff, rmeu_pkg::ERR_OK});
    add_row(mk(rmeu_pkg::ACT_ASSIGN, 2, 0, 0, 32'h80000000, 0, 0, 0, 0, 0), 1,
            '{10'd3, 1'b0, 1'b1, 32'h80000000, rmeu_pkg::ERR_OK});
    add_row(mk(rmeu_pkg::ACT_DIV, 3, 1, 1, 0, 0, 0, 0, 0, 0), 1,
            '{10'd4, 1'b0, 1'b0, 32'd0, rmeu_pkg::ERR_DIV0});
    add_row(mk(rmeu_pkg::ACT_MOD, 3, 1, 2, 0, 0, 0, 0, 0, 0), 1,
            '{10'd5, 1'b0, 1'b0, 32'd0, rmeu_pkg::ERR_DIV0});
    add_row(mk(rmeu_pkg::ACT_DIV, 4, 1, 2, 0, 0, 0, 32'hffffffff, 0, 0));
    add_row(mk(rmeu_pkg::ACT_MOD, 5, 1, 2, 0, 0, 0, 32'hffffffff, 0, 0));
    add_row(mk(rmeu_pkg::ACT_DIV, 6, 0, 0, -7, 0, 0, 2, 0, 0));
    add_row(mk(rmeu_pkg::ACT_MOD, 6, 0, 0, -7, 0, 0, 2, 0, 0));
    add_row(mk(rmeu_pkg::ACT_ADD, 7, 1, 1, 0, 0, 0, 1, 0, 0));
    add_row(mk(rmeu_pkg::ACT_SUB, 7, 1, 2, 0, 0, 0, 1, 0, 0));
    add_row(mk(rmeu_pkg::ACT_MUL, 8, 1, 1, 0, 1, 1, 0, 0, 0));
    add_row(mk(rmeu_pkg::ACT_INC, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(rmeu_pkg::ACT_DEC, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(rmeu_pkg::ACT_ACCESS, 9, 0, 0, 0, 0, 0, 0, 0, 7), 1,
            '{10'd15, 1'b0, 1'b0, 32'd0, rmeu_pkg::ERR_RANGE});
    add_row(mk(rmeu_pkg::ACT_APPEND, 0, 0, 0, 32'hdeadbeef, 0, 0, 0, 0, 7));
    add_row(mk(rmeu_pkg::ACT_ACCESS, 9, 0, 0, 0, 0, 0, 0, 0, 7));
    add_row(mk(rmeu_pkg::ACT_ACCESS, 9, 0, 0, -1, 0, 0, 0, 0, 7));
    add_row(mk(rmeu_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 7));
    add_row(mk(rmeu_pkg::ACT_JEQ, 0, 0, 0, 5, 0, 0, 5, 10'd1023, 0));
    add_row(mk(rmeu_pkg::ACT_JNE, 0, 0, 0, 5, 0, 0, 5, 10'd100, 0));
    add_row(mk(rmeu_pkg::ACT_JGT, 0, 0, 0, 1, 0, 0, -1, 10'd200, 0));
    add_row(mk(rmeu_pkg::ACT_JLT, 0, 0, 0, 1, 0, 0, -1, 10'd300, 0));
    add_row(mk(rmeu_pkg::ACT_JLE, 0, 0, 0, 3, 0, 0, 3, 10'd400, 0));
    add_row(mk(rmeu_pkg::ACT_JGE, 0, 0, 0, -4, 0, 0, 3, 10'd500, 0));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_word(rows[i].word, rows[i].typed, rows[i].result);
      idle_gap();
    end
    // fill array 5 past its capacity
    for (int i = 0; i < rmeu_pkg::ArrayDepth + 2; i++)
      send_word(mk(rmeu_pkg::ACT_APPEND, 0, 0, 0, $urandom, 0, 0, 0, 0, 5), 0, '0);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    for (int i = 0; i < 1950; i++) begin
      send_word(random_word(), 0, '0);
      idle_gap();
    end
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("register_machine_execute_unit_top test passed");
    else $display("register_machine_execute_unit_top test failed");
    $finish;
  end
endmodule
